// ----- hw/rtl/ssg_pkg.sv -----
// Shared types and constants of the Sobol sequence generator.
package ssg_pkg;

   localparam int NUM_DIMS      = 16;
   localparam int WORD_BITS     = 32;
   localparam int DIM_BITS      = $clog2(NUM_DIMS);
   localparam int BIT_BITS      = $clog2(WORD_BITS);
   localparam int DIM_CNT_BITS  = 5;
   localparam int DIR_ADDR_BITS = DIM_BITS + BIT_BITS;

   typedef logic [WORD_BITS-1:0]     word_type;
   typedef logic [DIM_BITS-1:0]      dim_idx_type;
   typedef logic [BIT_BITS-1:0]      bit_idx_type;
   typedef logic [DIM_CNT_BITS-1:0]  dim_cnt_type;
   typedef logic [DIR_ADDR_BITS-1:0] dir_addr_type;

   // Request kinds
   localparam logic [2:0] KIND_LOAD_DIR   = 3'd0;
   localparam logic [2:0] KIND_LOAD_SHIFT = 3'd1;
   localparam logic [2:0] KIND_RESTART    = 3'd2;
   localparam logic [2:0] KIND_NEXT       = 3'd3;
   localparam logic [2:0] KIND_SKIP       = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  dim_sel;
      logic [4:0]  bit_sel;
      logic [31:0] word_value;
      logic [31:0] target_index;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  out_dim;
      logic [31:0] integer_point;
      logic [31:0] sample;
      logic        last_of_point;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RB_READ,
      ST_RB_ACC,
      ST_ADV_BEGIN,
      ST_ADV_READ,
      ST_ADV_XOR,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic write_dir;
      logic write_shift;
      logic begin_rebuild;
      logic rebuild_restart;
      logic rb_read;
      logic rb_acc;
      logic begin_adv;
      logic adv_bump;
      logic adv_read;
      logic adv_apply;
      logic next_dim;
   } ctl_cmd_type;

   typedef struct packed {
      logic no_dims;
      logic last_dim;
      logic last_bit;
      logic rsp_taken;
   } dp_status_type;

endpackage

// ----- hw/rtl/ssg_datapath.sv -----
// Datapath: direction memory, sequence and shift words, point counter, result register.
module ssg_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  ssg_pkg::req_payload_type req_payload,
   input  logic                     csr_write_enable,
   input  logic [4:0]               csr_write_data,
   input  ssg_pkg::ctl_cmd_type     cmd,
   output ssg_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssg_pkg::rsp_payload_type rsp_payload
);

   ssg_pkg::word_type        dir_mem [2**ssg_pkg::DIR_ADDR_BITS];
   ssg_pkg::dir_addr_type    rd_addr;
   ssg_pkg::dir_addr_type    wr_addr;

   ssg_pkg::word_type        rd_data_ff;
   ssg_pkg::word_type        counter_ff,  counter_in;
   ssg_pkg::word_type        seq_ff   [ssg_pkg::NUM_DIMS];
   ssg_pkg::word_type        seq_in   [ssg_pkg::NUM_DIMS];
   ssg_pkg::word_type        shift_ff [ssg_pkg::NUM_DIMS];
   ssg_pkg::word_type        shift_in [ssg_pkg::NUM_DIMS];
   ssg_pkg::dim_idx_type     dim_ff,      dim_in;
   ssg_pkg::bit_idx_type     bit_ff,      bit_in;
   ssg_pkg::word_type        acc_ff,      acc_in;
   ssg_pkg::word_type        gray_ff,     gray_in;
   ssg_pkg::bit_idx_type     j_ff,        j_in;
   logic                     xor_en_ff,   xor_en_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ssg_pkg::rsp_payload_type rsp_ff,      rsp_in;
   ssg_pkg::dim_cnt_type     active_ff,   active_in;

   ssg_pkg::dim_cnt_type     n_dims;
   ssg_pkg::word_type        counter_plus;
   ssg_pkg::word_type        low_zero;
   ssg_pkg::bit_idx_type     low_zero_idx;
   ssg_pkg::word_type        acc_next;
   ssg_pkg::word_type        seq_xor;

   assign n_dims = (active_ff > ssg_pkg::dim_cnt_type'(ssg_pkg::NUM_DIMS))
                   ? ssg_pkg::dim_cnt_type'(ssg_pkg::NUM_DIMS) : active_ff;

   assign status.no_dims   = (n_dims == '0);
   assign status.last_dim  = ({1'b0, dim_ff} == n_dims - ssg_pkg::dim_cnt_type'(1));
   assign status.last_bit  = (bit_ff == ssg_pkg::bit_idx_type'(ssg_pkg::WORD_BITS - 1));
   assign status.rsp_taken = rsp_valid_ff && !rsp_stall;

   // lowest zero bit of the counter, one-hot; zero when the counter is all ones
   assign counter_plus = counter_ff + ssg_pkg::word_type'(1);
   assign low_zero     = ~counter_ff & counter_plus;

   always_comb begin
      low_zero_idx = '0;
      for (int k = 0; k < ssg_pkg::WORD_BITS; k++) begin
         if (low_zero[k]) begin
            low_zero_idx = low_zero_idx | ssg_pkg::bit_idx_type'(k);
         end
      end
   end

   assign rd_addr  = cmd.rb_read ? {dim_ff, bit_ff} : {dim_ff, j_ff};
   assign wr_addr  = {req_payload.dim_sel[ssg_pkg::DIM_BITS-1:0],
                      req_payload.bit_sel[ssg_pkg::BIT_BITS-1:0]};
   assign acc_next = acc_ff ^ (gray_ff[bit_ff] ? rd_data_ff : '0);
   assign seq_xor  = seq_ff[dim_ff] ^ (xor_en_ff ? rd_data_ff : '0);

   always_comb begin
      counter_in   = counter_ff;
      seq_in       = seq_ff;
      shift_in     = shift_ff;
      dim_in       = dim_ff;
      bit_in       = bit_ff;
      acc_in       = acc_ff;
      gray_in      = gray_ff;
      j_in         = j_ff;
      xor_en_in    = xor_en_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      active_in    = active_ff;

      if (csr_write_enable) begin
         active_in = csr_write_data;
      end
      if (cmd.write_shift) begin
         shift_in[req_payload.dim_sel[ssg_pkg::DIM_BITS-1:0]] = req_payload.word_value;
      end
      if (cmd.begin_rebuild) begin
         dim_in = '0;
         bit_in = '0;
         acc_in = '0;
         if (cmd.rebuild_restart) begin
            gray_in    = ssg_pkg::word_type'(1);
            counter_in = ssg_pkg::word_type'(1);
         end else begin
            gray_in    = req_payload.target_index ^ (req_payload.target_index >> 1);
            counter_in = req_payload.target_index;
         end
      end
      if (cmd.rb_acc) begin
         if (status.last_bit) begin
            seq_in[dim_ff] = acc_next;
            acc_in         = '0;
            bit_in         = '0;
            dim_in         = dim_ff + ssg_pkg::dim_idx_type'(1);
         end else begin
            acc_in = acc_next;
            bit_in = bit_ff + ssg_pkg::bit_idx_type'(1);
         end
      end
      if (cmd.begin_adv) begin
         dim_in    = '0;
         j_in      = low_zero_idx;
         xor_en_in = cmd.adv_bump && (low_zero != '0);
         if (cmd.adv_bump) begin
            counter_in = counter_plus;
         end
      end
      if (status.rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.adv_apply) begin
         seq_in[dim_ff]       = seq_xor;
         rsp_in.out_dim       = 4'(dim_ff);
         rsp_in.integer_point = seq_xor;
         rsp_in.sample        = seq_xor + shift_ff[dim_ff];
         rsp_in.last_of_point = status.last_dim;
         rsp_valid_in         = 1'b1;
      end
      if (cmd.next_dim) begin
         dim_in = dim_ff + ssg_pkg::dim_idx_type'(1);
      end
   end

   // direction memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_dir) begin
         dir_mem[wr_addr] <= req_payload.word_value;
      end
      if (cmd.rb_read || cmd.adv_read) begin
         rd_data_ff <= dir_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         seq_ff       <= '{default: '0};
         shift_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         active_ff    <= ssg_pkg::dim_cnt_type'(ssg_pkg::NUM_DIMS);
      end else begin
         counter_ff   <= counter_in;
         seq_ff       <= seq_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      dim_ff     <= dim_in;
      bit_ff     <= bit_in;
      acc_ff     <= acc_in;
      gray_ff    <= gray_in;
      j_ff       <= j_in;
      xor_en_ff  <= xor_en_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- hw/rtl/ssg_ctrl.sv -----
// Controller state machine of the Sobol sequence generator.
module ssg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssg_pkg::req_payload_type req_payload,
   input  ssg_pkg::dp_status_type   status,
   output ssg_pkg::ctl_cmd_type     cmd
);

   ssg_pkg::state_type state_ff, state_in;
   logic               restart_ff, restart_in;
   logic               req_accept;
   logic               target_zero;

   assign req_stall   = (state_ff != ssg_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign target_zero = (req_payload.target_index == '0);

   // next state
   always_comb begin
      state_in   = state_ff;
      restart_in = restart_ff;
      unique case (state_ff)
         ssg_pkg::ST_IDLE: begin
            if (req_accept) begin
               restart_in = (req_payload.kind == ssg_pkg::KIND_RESTART);
               if ((req_payload.kind == ssg_pkg::KIND_RESTART) ||
                   ((req_payload.kind == ssg_pkg::KIND_SKIP) && !target_zero)) begin
                  state_in = status.no_dims ? ssg_pkg::ST_ADV_BEGIN : ssg_pkg::ST_RB_READ;
               end else if (req_payload.kind == ssg_pkg::KIND_NEXT) begin
                  state_in = status.no_dims ? ssg_pkg::ST_IDLE : ssg_pkg::ST_ADV_READ;
               end
            end
         end
         ssg_pkg::ST_RB_READ: begin
            state_in = ssg_pkg::ST_RB_ACC;
         end
         ssg_pkg::ST_RB_ACC: begin
            state_in = (status.last_bit && status.last_dim) ? ssg_pkg::ST_ADV_BEGIN
                                                            : ssg_pkg::ST_RB_READ;
         end
         ssg_pkg::ST_ADV_BEGIN: begin
            state_in = status.no_dims ? ssg_pkg::ST_IDLE : ssg_pkg::ST_ADV_READ;
         end
         ssg_pkg::ST_ADV_READ: begin
            state_in = ssg_pkg::ST_ADV_XOR;
         end
         ssg_pkg::ST_ADV_XOR: begin
            state_in = ssg_pkg::ST_EMIT;
         end
         ssg_pkg::ST_EMIT: begin
            if (status.rsp_taken) begin
               state_in = status.last_dim ? ssg_pkg::ST_IDLE : ssg_pkg::ST_ADV_READ;
            end
         end
         default: begin
            state_in = ssg_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ssg_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd.write_dir       = (req_payload.kind == ssg_pkg::KIND_LOAD_DIR);
               cmd.write_shift     = (req_payload.kind == ssg_pkg::KIND_LOAD_SHIFT);
               cmd.begin_rebuild   = (req_payload.kind == ssg_pkg::KIND_RESTART) ||
                                     ((req_payload.kind == ssg_pkg::KIND_SKIP) && !target_zero);
               cmd.rebuild_restart = (req_payload.kind == ssg_pkg::KIND_RESTART);
               cmd.begin_adv       = (req_payload.kind == ssg_pkg::KIND_NEXT);
               cmd.adv_bump        = 1'b1;
            end
         end
         ssg_pkg::ST_RB_READ: begin
            cmd.rb_read = 1'b1;
         end
         ssg_pkg::ST_RB_ACC: begin
            cmd.rb_acc = 1'b1;
         end
         ssg_pkg::ST_ADV_BEGIN: begin
            cmd.begin_adv = 1'b1;
            cmd.adv_bump  = !restart_ff;
         end
         ssg_pkg::ST_ADV_READ: begin
            cmd.adv_read = 1'b1;
         end
         ssg_pkg::ST_ADV_XOR: begin
            cmd.adv_apply = 1'b1;
         end
         ssg_pkg::ST_EMIT: begin
            cmd.next_dim = status.rsp_taken;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssg_pkg::ST_IDLE;
         restart_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         restart_ff <= restart_in;
      end
   end

endmodule

// ----- hw/rtl/sobol_sequence_generator_top.sv -----
// Top level of the Gray-code Sobol point generator: controller plus datapath.
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_stall      req_payload (req_payload_type)
//   rsp_      out        rsp_valid / rsp_stall      rsp_payload (rsp_payload_type)
//   csr_      in         csr_write_enable           csr_write_data (active_dims)
//
// Sequencing: load requests are taken in the idle state. A next-point request walks the
//   N active dimensions with one direction-memory read, one xor and one result per
//   dimension. Restart and skip to a non-zero index first rebuild every active word through
//   the single memory read port, with a read state and an accumulate state per table bit.
// Reset: synchronous, active high; clears the counter, sequence and shift words and
//   sets active_dims to 16. The direction memory holds garbage until loaded.
// Stalls: rsp_stall holds the current result and freezes the sequence; requests are
//   stalled from acceptance until the last coordinate of the point is taken.
module sobol_sequence_generator_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssg_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssg_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [4:0]               csr_write_data
);

   ssg_pkg::ctl_cmd_type   cmd;
   ssg_pkg::dp_status_type status;

   // sequencing: accept requests, walk dimensions and table bits
   ssg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .status      (status),
      .cmd         (cmd)
   );

   // storage and arithmetic: memory reads, xor into sequence words, shift wrap-add
   ssg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

`ifndef SYNTH
   // a pending result always blocks new requests
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // taking the final coordinate frees the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_payload.last_of_point) |=> !req_stall)
      else $error("block still busy after the last coordinate of a point");

   // an applied xor step always presents a result next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.adv_apply |=> rsp_valid)
      else $error("result register not loaded after the xor step");
`endif

endmodule
